[sv/htb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Huffman tree builder.
// Depends on nothing; used by huffman_tree_builder_unit.
package htb_pkg;

   // Default leaf capacity of one build
   localparam int MAX_LEAVES_DEF = 16;

   // Field widths fixed by the request and response formats
   localparam int LEAF_W   = 16;
   localparam int WEIGHT_W = 20;
   localparam int INDEX_W  = 5;

   // Largest parent weight; sums saturate here
   localparam logic [WEIGHT_W-1:0] WEIGHT_SAT = {WEIGHT_W{1'b1}};

   // One leaf request
   typedef struct packed {
      logic [LEAF_W-1:0] leaf_weight;
      logic              last_leaf;
   } req_type;

   // One merge record
   typedef struct packed {
      logic [INDEX_W-1:0]  node_index;
      logic [INDEX_W-1:0]  left_child;
      logic [INDEX_W-1:0]  right_child;
      logic [WEIGHT_W-1:0] sum_weight;
      logic                final_merge;
      logic                no_merge;
      logic                leaves_dropped;
   } rsp_type;

   // Controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_MERGE = 3'b100
   } state_type;

endpackage

[sv/huffman_tree_builder_unit.sv]
`timescale 1ns / 1ps
// Huffman tree builder: leaf loading, scan-and-merge sequencer, node weight memory.
// Depends on htb_pkg for the request/response types, widths and states.
//
// Usage:
//   A leaf request is taken on a rising edge with start high and busy low.
//   Leaves go into the node memory one per cycle while busy is low. A
//   request with last_leaf set closes the set and starts the build; busy
//   stays high until the build is done. Leaves beyond MAX_LEAVES are
//   dropped, and every record of that build carries leaves_dropped.
//   Each parent node gives one record on rsp_data, shown for exactly one
//   cycle with rsp_strobe high; the receiver cannot hold it off. The last
//   record of a build has final_merge set. A build of one leaf gives a
//   single record with no_merge set, in the cycle after the request, and
//   never raises busy.
//   Build: a build over n leaves runs rounds k = n .. 2n-2; round k scans
//   nodes 0..k-1 through the single read port of the node memory (one
//   node a cycle, then a step to fold the last read and one to close the
//   scan) and then merges. Record k is registered in the merge state and
//   leaves in the cycle after it.
//   Reset (synchronous, active high) empties the leaf set and clears all
//   merge flags; the node memory needs no clearing.
module huffman_tree_builder_unit #(
   parameter int MAX_LEAVES = htb_pkg::MAX_LEAVES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  htb_pkg::req_type req_data,
   output logic             rsp_strobe,
   output htb_pkg::rsp_type rsp_data
);

   localparam int NODE_DEPTH = 2 * MAX_LEAVES - 1;
   localparam int IW         = $clog2(NODE_DEPTH);
   localparam int CW         = $clog2(MAX_LEAVES + 1);
   localparam int WW         = htb_pkg::WEIGHT_W;

   // Node weight memory: one write port, one registered read port
   logic [WW-1:0] node_mem [NODE_DEPTH];
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [WW-1:0] wr_data;
   logic [WW-1:0] rd_data_ff;

   // Control state
   htb_pkg::state_type state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  ovf_ff, ovf_in;
   logic [IW-1:0]         k_ff, k_in;
   logic [IW-1:0]         last_k_ff, last_k_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [IW-1:0]         pend_idx_ff, pend_idx_in;
   logic                  pend_merged_ff, pend_merged_in;
   logic [NODE_DEPTH-1:0] merged_ff, merged_in;

   // Running picks of the scan
   logic          have1_ff, have1_in;
   logic          have2_ff, have2_in;
   logic [IW-1:0] a_ff, a_in;
   logic [IW-1:0] b_ff, b_in;
   logic [WW-1:0] w1_ff, w1_in;
   logic [WW-1:0] w2_ff, w2_in;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   htb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          store;
   logic [CW-1:0] n_new;
   logic          issue;
   logic [WW:0]   sum_raw;
   logic [WW-1:0] sum_sat;

   assign busy       = (state_ff != htb_pkg::ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign accept  = start && !busy;
   assign store   = accept && (cnt_ff < CW'(MAX_LEAVES));
   assign n_new   = store ? cnt_ff + CW'(1) : cnt_ff;
   assign issue   = (idx_ff < k_ff);
   assign sum_raw = {1'b0, w1_ff} + {1'b0, w2_ff};
   assign sum_sat = sum_raw[WW] ? htb_pkg::WEIGHT_SAT : sum_raw[WW-1:0];

   // Select the memory write: leaf store while idle, parent weight on merge
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = IW'(cnt_ff);
      wr_data = {{(WW - htb_pkg::LEAF_W){1'b0}}, req_data.leaf_weight};
      if (state_ff == htb_pkg::ST_IDLE) begin
         wr_en = store;
      end else if (state_ff == htb_pkg::ST_MERGE) begin
         wr_en   = 1'b1;
         wr_addr = k_ff;
         wr_data = sum_sat;
      end
   end

   // Node memory: write, and read the scan address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= node_mem[idx_ff];
   end

   // Sequencer next state
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      ovf_in         = ovf_ff;
      k_in           = k_ff;
      last_k_in      = last_k_ff;
      idx_in         = idx_ff;
      pend_in        = 1'b0;
      pend_idx_in    = idx_ff;
      pend_merged_in = merged_ff[idx_ff];
      merged_in      = merged_ff;
      have1_in       = have1_ff;
      have2_in       = have2_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      w1_in          = w1_ff;
      w2_in          = w2_ff;
      rsp_valid_in   = 1'b0;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         htb_pkg::ST_IDLE: begin
            if (accept) begin
               cnt_in = n_new;
               ovf_in = ovf_ff | !store;
               if (req_data.last_leaf) begin
                  if (n_new <= CW'(1)) begin
                     // Single leaf: report it directly and drop the set
                     rsp_valid_in                = 1'b1;
                     rsp_data_in.node_index      = '0;
                     rsp_data_in.left_child      = '0;
                     rsp_data_in.right_child     = '0;
                     rsp_data_in.sum_weight      = wr_data;
                     rsp_data_in.final_merge     = 1'b1;
                     rsp_data_in.no_merge        = 1'b1;
                     rsp_data_in.leaves_dropped  = ovf_ff;
                     cnt_in                      = '0;
                     ovf_in                      = 1'b0;
                  end else begin
                     // Start the build with the first parent at index n
                     k_in      = IW'(n_new);
                     last_k_in = IW'({n_new, 1'b0} - (CW + 1)'(2));
                     idx_in    = '0;
                     have1_in  = 1'b0;
                     have2_in  = 1'b0;
                     state_in  = htb_pkg::ST_SCAN;
                  end
               end
            end
         end

         htb_pkg::ST_SCAN: begin
            // Issue reads over nodes 0..k-1
            if (issue) begin
               idx_in  = idx_ff + IW'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               state_in = htb_pkg::ST_MERGE;
            end
            // Fold returned node into the two lightest, lowest index on ties
            if (pend_ff && !pend_merged_ff) begin
               if (!have1_ff) begin
                  have1_in = 1'b1;
                  a_in     = pend_idx_ff;
                  w1_in    = rd_data_ff;
               end else if (rd_data_ff < w1_ff) begin
                  have2_in = 1'b1;
                  b_in     = a_ff;
                  w2_in    = w1_ff;
                  a_in     = pend_idx_ff;
                  w1_in    = rd_data_ff;
               end else if (!have2_ff || rd_data_ff < w2_ff) begin
                  have2_in = 1'b1;
                  b_in     = pend_idx_ff;
                  w2_in    = rd_data_ff;
               end
            end
         end

         htb_pkg::ST_MERGE: begin
            // Emit the record, mark both children, append the parent
            rsp_valid_in               = 1'b1;
            rsp_data_in.node_index     = htb_pkg::INDEX_W'(k_ff);
            rsp_data_in.left_child     = htb_pkg::INDEX_W'(a_ff);
            rsp_data_in.right_child    = htb_pkg::INDEX_W'(b_ff);
            rsp_data_in.sum_weight     = sum_sat;
            rsp_data_in.final_merge    = (k_ff == last_k_ff);
            rsp_data_in.no_merge       = 1'b0;
            rsp_data_in.leaves_dropped = ovf_ff;
            merged_in[a_ff]            = 1'b1;
            merged_in[b_ff]            = 1'b1;
            if (k_ff == last_k_ff) begin
               merged_in = '0;
               cnt_in    = '0;
               ovf_in    = 1'b0;
               state_in  = htb_pkg::ST_IDLE;
            end else begin
               k_in     = k_ff + IW'(1);
               idx_in   = '0;
               have1_in = 1'b0;
               have2_in = 1'b0;
               state_in = htb_pkg::ST_SCAN;
            end
         end

         default: begin
            state_in = htb_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= htb_pkg::ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         merged_ff    <= '0;
         have1_ff     <= 1'b0;
         have2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         merged_ff    <= merged_in;
         have1_ff     <= have1_in;
         have2_ff     <= have2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff           <= k_in;
      last_k_ff      <= last_k_in;
      idx_ff         <= idx_in;
      pend_idx_ff    <= pend_idx_in;
      pend_merged_ff <= pend_merged_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      w1_ff          <= w1_in;
      w2_ff          <= w2_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // A build ends only together with its root record
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe && rsp_data.final_merge)
      else $error("build ended without a final record");

   // Both picks exist, differ and are still unmerged at merge time
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == htb_pkg::ST_MERGE) |->
         have1_ff && have2_ff && (a_ff != b_ff) && !merged_ff[a_ff] && !merged_ff[b_ff])
      else $error("bad child picks at merge");

   // A no-merge record is always the final one
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.no_merge |-> rsp_data.final_merge && !busy)
      else $error("no-merge record not final");

   // Merge flags are all clear between builds
   assert property (@(posedge clock) disable iff (reset)
      !busy |-> (merged_ff == '0))
      else $error("merge flags left set while idle");

endmodule

[tb/sv/huffman_tree_builder_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for huffman_tree_builder_unit: leaf sets are loaded through
// the start/busy port and every merge record is checked against a built-in tree model.
// Depends on htb_pkg for the request/response types and widths.
module huffman_tree_builder_unit_tb;
   import htb_pkg::*;

   localparam int LEAF_CAP      = MAX_LEAVES_DEF;
   localparam int NODE_SLOTS    = 2 * LEAF_CAP - 1;
   localparam int RANDOM_ITEMS  = 210;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 3000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    rsp_strobe;
   req_type req_data;
   rsp_type rsp_data;

   // Tree model state: node weights, merged marks, leaf count, drop flag
   logic [WEIGHT_W-1:0] node_wt [NODE_SLOTS];
   bit                  node_done [NODE_SLOTS];
   int                  leaf_total;
   bit                  drop_seen;

   // Merge records still due from the block, oldest first
   rsp_type merges_due[$];
   rsp_type want_rec;

   int  err_count;
   int  stall_cycles;
   int  items_sent;
   bit  no_idle;

   huffman_tree_builder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Lowest index of the lightest unmerged node below upto, other than skip
   function automatic int pick_lightest_node(int upto, int skip);
      int                  best;
      bit                  found;
      logic [WEIGHT_W-1:0] best_wt;
      best    = 0;
      found   = 1'b0;
      best_wt = '0;
      for (int i = 0; i < upto; i++) begin
         if (node_done[i] || i == skip) continue;
         if (!found || node_wt[i] < best_wt) begin
            found   = 1'b1;
            best    = i;
            best_wt = node_wt[i];
         end
      end
      return best;
   endfunction

   // Store one leaf; on the last mark, build the tree and queue its merge records
   function automatic void load_leaf(req_type item);
      rsp_type           rec;
      int                n;
      int                a;
      int                b;
      logic [WEIGHT_W:0] sum_full;
      if (leaf_total < LEAF_CAP) begin
         node_wt[leaf_total]   = WEIGHT_W'(item.leaf_weight);
         node_done[leaf_total] = 1'b0;
         leaf_total++;
      end else begin
         drop_seen = 1'b1;
      end
      if (!item.last_leaf) return;

      n = leaf_total;
      foreach (node_done[i]) node_done[i] = 1'b0;
      if (n <= 1) begin
         rec.node_index     = '0;
         rec.left_child     = '0;
         rec.right_child    = '0;
         rec.sum_weight     = node_wt[0];
         rec.final_merge    = 1'b1;
         rec.no_merge       = 1'b1;
         rec.leaves_dropped = drop_seen;
         merges_due.push_back(rec);
      end else begin
         for (int k = n; k < 2 * n - 1; k++) begin
            a = pick_lightest_node(k, NODE_SLOTS);
            b = pick_lightest_node(k, a);
            sum_full = {1'b0, node_wt[a]} + {1'b0, node_wt[b]};
            if (sum_full > {1'b0, WEIGHT_SAT}) sum_full = {1'b0, WEIGHT_SAT};
            node_done[a] = 1'b1;
            node_done[b] = 1'b1;
            node_wt[k]   = sum_full[WEIGHT_W-1:0];
            node_done[k] = 1'b0;
            rec.node_index     = INDEX_W'(k);
            rec.left_child     = INDEX_W'(a);
            rec.right_child    = INDEX_W'(b);
            rec.sum_weight     = sum_full[WEIGHT_W-1:0];
            rec.final_merge    = (k == 2 * n - 2);
            rec.no_merge       = 1'b0;
            rec.leaves_dropped = drop_seen;
            merges_due.push_back(rec);
         end
      end
      // Clear for the next leaf set
      foreach (node_done[i]) node_done[i] = 1'b0;
      leaf_total = 0;
      drop_seen  = 1'b0;
   endfunction

   // Check each record, then take in any accepted request, and watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (merges_due.size() == 0) begin
               $display("%0t: unexpected record %p", $time, rsp_data);
               err_count++;
            end else begin
               want_rec = merges_due.pop_front();
               if (rsp_data.node_index !== want_rec.node_index ||
                   rsp_data.left_child !== want_rec.left_child ||
                   rsp_data.right_child !== want_rec.right_child ||
                   rsp_data.sum_weight !== want_rec.sum_weight ||
                   rsp_data.final_merge !== want_rec.final_merge ||
                   rsp_data.no_merge !== want_rec.no_merge ||
                   rsp_data.leaves_dropped !== want_rec.leaves_dropped) begin
                  $display("%0t: record mismatch expected %p actual %p",
                           $time, want_rec, rsp_data);
                  err_count++;
               end
            end
         end
         if (start && busy === 1'b0) load_leaf(req_data);

         if (rsp_strobe === 1'b1 || (start && busy === 1'b0)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one leaf request and hold it until the block takes it
   task automatic send_leaf(input logic [LEAF_W-1:0] wt, input logic last);
      int gap;
      gap = no_idle ? 0 : draw_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start                <= 1'b1;
      req_data.leaf_weight <= wt;
      req_data.last_leaf   <= last;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
   endtask

   // Hold off new requests until every due record has come, then let the block settle
   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (merges_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One-leaf builds at both weight extremes
   task automatic test_single_leaf();
      send_leaf('0, 1'b1);
      send_leaf('1, 1'b1);
   endtask

   // Two-leaf builds, one ordered and one tied
   task automatic test_pairs_and_ties();
      send_leaf(16'd5, 1'b0);
      send_leaf(16'd3, 1'b1);
      send_leaf(16'd7, 1'b0);
      send_leaf(16'd7, 1'b1);
   endtask

   // Full set of maximum weights with one zero leaf, then a last leaf past capacity
   task automatic test_capacity_overflow();
      for (int i = 0; i < LEAF_CAP; i++) send_leaf((i == 3) ? '0 : '1, 1'b0);
      send_leaf(16'h1234, 1'b1);
   endtask

   // Random leaf sets: mostly small, some larger up to capacity, a few past capacity
   task automatic test_random_builds();
      int                sent;
      int                set_size;
      int                style;
      int                r;
      logic [LEAF_W-1:0] wt;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 60) set_size = $urandom_range(1, 5);
         else if (r < 85) set_size = $urandom_range(6, LEAF_CAP);
         else set_size = $urandom_range(LEAF_CAP + 1, LEAF_CAP + 4);
         style   = $urandom_range(0, 3);
         no_idle = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < set_size; i++) begin
            case (style)
               0: wt = LEAF_W'($urandom);
               1: wt = LEAF_W'($urandom_range(0, 7));
               2: wt = $urandom_range(0, 1) ? '1 : '0;
               default: begin
                  r  = $urandom_range(0, 3);
                  wt = (r == 0) ? '0 : (r == 1) ? '1 : LEAF_W'($urandom);
               end
            endcase
            send_leaf(wt, i == set_size - 1);
            sent++;
         end
         no_idle = 1'b0;
         if ($urandom_range(0, 6) == 0) wait_for_drain();
      end
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      leaf_total = 0;
      drop_seen  = 1'b0;
      err_count  = 0;
      items_sent = 0;
      no_idle    = 1'b0;
      foreach (node_done[i]) node_done[i] = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_leaf();
      test_pairs_and_ties();
      wait_for_drain();
      test_capacity_overflow();
      test_random_builds();
      wait_for_drain();

      if (err_count == 0 && merges_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
